@@ rtl/core/wis_pkg.sv @@
// Package: opcodes, size constants and shared types for the word insertion sorter.
package wis_pkg;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    localparam int MAX_WORDS = 256;
    localparam int MAX_CHARS = 48;
    localparam int WW = $clog2(MAX_WORDS);
    localparam int NW = $clog2(MAX_WORDS + 1);
    localparam int CW = $clog2(MAX_CHARS);
    localparam int LW = $clog2(MAX_CHARS + 1);

    typedef struct packed {
        logic [7:0] read_byte;
        logic [5:0] word_length;
        logic       overflow;
    } t_result;

endpackage

@@ rtl/core/wis_store.sv @@
// Word store: byte memory, length memory, build buffer and the insertion sequencer.
module wis_store (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [1:0]             i_opcode,
    input  logic [7:0]             i_char_byte,
    input  logic [7:0]             i_word_index,
    input  logic [5:0]             i_char_pos,
    output logic                   o_busy,
    output logic                   o_done,
    output wis_pkg::t_result       o_result,
    output logic [wis_pkg::NW-1:0] o_count
);
    import wis_pkg::*;

    localparam int AW = WW + CW;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RDL   = 4'd1;
    localparam logic [3:0] S_RDB   = 4'd2;
    localparam logic [3:0] S_LLEN  = 4'd3;
    localparam logic [3:0] S_CMP   = 4'd4;
    localparam logic [3:0] S_CMPW  = 4'd5;
    localparam logic [3:0] S_MOVE  = 4'd6;
    localparam logic [3:0] S_PUT   = 4'd7;
    localparam logic [3:0] S_RD1   = 4'd8;
    localparam logic [3:0] S_RD2   = 4'd9;

    logic [7:0] r_bytes [MAX_WORDS*(2**CW)];
    logic [LW-1:0] r_lens [MAX_WORDS];
    logic [7:0] r_buf [MAX_CHARS];
    logic [7:0] r_bb;
    logic [LW-1:0] r_blen;
    logic [NW-1:0] r_count;
    logic [3:0] r_st;
    logic [NW-1:0] r_idx;
    logic [CW-1:0] r_pos;
    logic [LW-1:0] r_elen;
    logic [7:0] r_rd;
    logic [LW-1:0] r_lrd;
    logic [7:0] r_rpos_hold;
    logic r_done;
    t_result r_res;

    logic          m_we;
    logic [AW-1:0] m_wa, m_ra;
    logic [7:0]    m_wd;
    logic          l_we;
    logic [WW-1:0] l_wa, l_ra;
    logic [LW-1:0] l_wd;
    logic          b_we;
    logic [CW-1:0] b_wa, b_ra;

    logic          w_drop;
    logic          w_rd_ok;
    logic          w_fin;

    always_ff @(posedge i_clk) begin
        if (m_we) r_bytes[m_wa] <= m_wd;
        r_rd <= r_bytes[m_ra];
        if (l_we) r_lens[l_wa] <= l_wd;
        r_lrd <= r_lens[l_ra];
        if (b_we) r_buf[b_wa] <= i_char_byte;
        r_bb <= r_buf[b_ra];
    end

    logic [NW-1:0] w_prev;
    logic [LW-1:0] w_mlen;
    assign w_prev = r_idx - 1'b1;
    assign w_mlen = (r_blen < r_elen) ? r_blen : r_elen;

    assign w_drop = (i_opcode == OP_APPEND && r_blen >= LW'(MAX_CHARS)) ||
                    (i_opcode == OP_INSERT && r_count >= NW'(MAX_WORDS));
    assign w_rd_ok = NW'(i_word_index) < r_count;
    assign w_fin = (r_st == S_IDLE && i_start &&
                    !(i_opcode == OP_READ && w_rd_ok) &&
                    !(i_opcode == OP_INSERT && !w_drop)) ||
                   (r_st == S_RD2) ||
                   (r_st == S_PUT && r_pos == CW'(MAX_CHARS - 1));

    assign b_we = (r_st == S_IDLE) && i_start && (i_opcode == OP_APPEND) && !w_drop;
    assign b_wa = r_blen;

    always_comb begin
        m_we = 1'b0; m_wa = '0; m_wd = r_rd; m_ra = '0;
        l_we = 1'b0; l_wa = '0; l_wd = r_elen; l_ra = '0;
        b_ra = '0;
        unique case (r_st)
            S_IDLE, S_RD1, S_RD2: begin
                l_ra = i_word_index[WW-1:0];
                m_ra = {i_word_index[WW-1:0], i_char_pos[CW-1:0]};
                if (r_st != S_IDLE) begin
                    l_ra = r_rpos_hold[WW-1:0];
                    m_ra = {r_rpos_hold[WW-1:0], r_pos};
                end
            end
            S_RDL: l_ra = w_prev[WW-1:0];
            S_LLEN, S_RDB: m_ra = {w_prev[WW-1:0], r_pos};
            S_CMP: m_ra = {w_prev[WW-1:0], r_pos};
            S_CMPW: begin
                m_ra = {w_prev[WW-1:0], r_pos};
                b_ra = r_pos;
            end
            S_MOVE: begin
                m_ra = {w_prev[WW-1:0], r_pos + 1'b1};
                m_we = 1'b1;
                m_wa = {r_idx[WW-1:0], r_pos};
                if (r_pos == '0) begin
                    l_we = 1'b1; l_wa = r_idx[WW-1:0];
                end
            end
            S_PUT: begin
                m_we = ({1'b0, r_pos} < (CW+1)'(r_blen));
                m_wa = {r_idx[WW-1:0], r_pos};
                m_wd = r_bb;
                l_we = (r_pos == '0);
                l_wa = r_idx[WW-1:0];
                l_wd = r_blen;
                b_ra = (r_pos == CW'(MAX_CHARS - 1)) ? '0 : r_pos + 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_blen <= '0; r_count <= '0; r_done <= 1'b0;
        end else begin
            r_done <= w_fin;
            unique case (r_st)
                S_IDLE: if (i_start) begin
                    r_res <= '{read_byte: 8'd0, word_length: 6'd0, overflow: w_drop};
                    r_rpos_hold <= i_word_index;
                    r_pos <= (i_opcode == OP_READ) ? i_char_pos[CW-1:0] : '0;
                    case (i_opcode)
                        OP_APPEND: begin
                            if (!w_drop) r_blen <= r_blen + 1'b1;
                        end
                        OP_INSERT: begin
                            if (w_drop) r_blen <= '0;
                            else begin
                                r_idx <= r_count;
                                r_st <= (r_count == '0) ? S_PUT : S_RDL;
                            end
                        end
                        OP_READ: begin
                            if (w_rd_ok) r_st <= S_RD1;
                        end
                        default: ;
                    endcase
                end
                S_RD1: r_st <= S_RD2;
                S_RD2: begin
                    r_res <= '{read_byte: (r_pos < r_lrd) ? r_rd : 8'd0,
                               word_length: r_lrd, overflow: 1'b0};
                    r_st <= S_IDLE;
                end
                S_RDL: r_st <= S_LLEN;
                S_LLEN: begin r_elen <= r_lrd; r_st <= S_CMPW; end
                S_CMPW: r_st <= S_CMP;
                S_CMP: begin
                    if (LW'(r_pos) < w_mlen && r_bb == r_rd) begin
                        r_pos <= r_pos + 1'b1; r_st <= S_CMPW;
                    end else if ((LW'(r_pos) < w_mlen && r_bb < r_rd) ||
                                 (LW'(r_pos) >= w_mlen && r_blen < r_elen)) begin
                        r_pos <= '0; r_st <= S_RDB;
                    end else begin
                        r_pos <= '0; r_st <= S_PUT;
                    end
                end
                S_RDB: r_st <= S_MOVE;
                S_MOVE: begin
                    if (r_pos == CW'(MAX_CHARS - 1)) begin
                        r_pos <= '0; r_idx <= w_prev;
                        r_st <= (w_prev == '0) ? S_PUT : S_RDL;
                    end else r_pos <= r_pos + 1'b1;
                end
                S_PUT: begin
                    if (r_pos == CW'(MAX_CHARS - 1)) begin
                        r_count <= r_count + 1'b1; r_blen <= '0;
                        r_st <= S_IDLE;
                    end else r_pos <= r_pos + 1'b1;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_busy = (r_st != S_IDLE) || r_done;
    assign o_done = r_done;
    assign o_result = r_res;
    assign o_count = r_count;

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NW'(MAX_WORDS)) else $error("count over limit");
    a_blen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_blen <= LW'(MAX_CHARS)) else $error("build length over limit");
    a_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_st) != S_IDLE || $past(i_start)) else $error("spurious done");
endmodule

@@ rtl/core/word_insertion_sorter.sv @@
// Top level of the word insertion sorter.
// Request channel: opcode, char_byte, word_index, char_pos with i_valid/o_stall.
// Result channel: one result per request with o_valid/i_stall, held in a register.
// One request is in flight at a time; o_stall stays high until its result is taken.
// Append, unused opcode, dropped insert, out-of-range read: the store finishes in the
// accepting cycle, and o_valid follows through the r_done and r_valid registers.
// In-range read: the store passes S_RD1 and S_RD2, then r_done and r_valid.
// Insert walks down from the end of the table. Per entry moved up: S_RDL and S_LLEN
// fetch its length, S_CMPW and S_CMP compare the words byte by byte, and S_RDB and
// S_MOVE copy the row. The new row is then written in S_PUT.
// A full table or an over-long word drops the data and raises overflow.
// Reset empties the table and the build buffer; no memory clearing is needed.
// While the receiver stalls, the result is held and no new request is taken.
module word_insertion_sorter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_char_byte,
    input  logic [7:0] i_word_index,
    input  logic [5:0] i_char_pos,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_read_byte,
    output logic [5:0] o_word_length,
    output logic [8:0] o_word_count,
    output logic       o_overflow
);
    import wis_pkg::*;

    logic w_busy, w_done, w_start;
    t_result w_res;
    logic [NW-1:0] w_cnt;
    logic r_valid;

    assign o_stall = w_busy || r_valid;
    assign w_start = i_valid && !o_stall;

    wis_store u_store (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start),
        .i_opcode(i_opcode), .i_char_byte(i_char_byte),
        .i_word_index(i_word_index), .i_char_pos(i_char_pos),
        .o_busy(w_busy), .o_done(w_done), .o_result(w_res), .o_count(w_cnt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else if (w_done) begin
            r_valid <= 1'b1;
            o_read_byte <= w_res.read_byte;
            o_word_length <= w_res.word_length;
            o_overflow <= w_res.overflow;
            o_word_count <= w_cnt;
        end else if (!i_stall) r_valid <= 1'b0;
    end
    assign o_valid = r_valid;
endmodule
